>>> rtl/dcl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dcl_pkg;

  localparam int unsigned CountW   = 16;
  localparam int unsigned QuotW    = 11;
  localparam int unsigned CoefW    = 10;
  localparam int unsigned SegN     = 7;
  localparam int unsigned ProdW    = 26;
  localparam int unsigned LuxShift = 10;
  localparam int unsigned LuxW     = 16;

  typedef struct packed {
    logic             zero;
    logic             over;
    logic [QuotW-1:0] quot;
  } ratio_t;

  typedef struct packed {
    logic [CoefW-1:0] b;
    logic [CoefW-1:0] m;
  } coef_t;

  // ratio breakpoints at 2^9 scale, with intercept and slope per segment
  localparam logic [CoefW-1:0] SegLimit [SegN] = '{
    10'h040, 10'h080, 10'h0C0, 10'h100, 10'h138, 10'h19A, 10'h29A
  };
  localparam logic [CoefW-1:0] SegB [SegN] = '{
    10'h1F2, 10'h214, 10'h23F, 10'h270, 10'h16F, 10'h0D2, 10'h018
  };
  localparam logic [CoefW-1:0] SegM [SegN] = '{
    10'h1BE, 10'h2D1, 10'h37B, 10'h3FE, 10'h1FC, 10'h0FB, 10'h012
  };

  localparam logic [ProdW:0] LuxRound = (ProdW+1)'(1) << (LuxShift - 1);

  // one restoring division step: {quotient bit, new remainder}
  function automatic logic [CountW:0] div_step(logic [CountW-1:0] rem,
                                               logic [CountW-1:0] dvs);
    logic [CountW:0] t;
    logic [CountW:0] diff;
    t    = {rem, 1'b0};
    diff = t - {1'b0, dvs};
    if (t >= {1'b0, dvs}) begin
      div_step = {1'b1, diff[CountW-1:0]};
    end else begin
      div_step = {1'b0, t[CountW-1:0]};
    end
  endfunction

  // unrounded quotient q maps to rounded ratio (q+1)>>1, so ratio <= L iff q <= 2L
  function automatic coef_t seg_pick(ratio_t r);
    coef_t res;
    res = '0;
    if (r.zero) begin
      res.b = SegB[0];
      res.m = SegM[0];
    end else if (!r.over) begin
      for (int i = SegN - 1; i >= 0; i--) begin
        if (r.quot <= {SegLimit[i], 1'b0}) begin
          res.b = SegB[i];
          res.m = SegM[i];
        end
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/dual_channel_lux_calculation.sv
// Lux from a broadband and an infrared photodiode count.
// Input channel: valid_i / stall_o with broadband_count_i and infrared_count_i;
// a transaction takes place on a rising edge with valid_i high and stall_o low.
// Output channel: valid_o / stall_i with lux_o, one result per input transaction,
// in order.
// Between input transaction and valid_o, four stages form the
// infrared/broadband ratio (integer bit, then 4, 3 and 3 quotient bits), one
// picks the segment coefficients, one holds the two 16x10 products, one
// subtracts, rounds, clamps and saturates.
// Throughput is one transaction per cycle whenever stall_o is low. Each stage
// loads when it is empty or the next stage moves, so bubbles fill in behind a
// stalled result and stall_o rises only once all seven stages hold data and
// stall_i is high. A stalled result stays on lux_o unchanged.
// Reset clears all stage valid bits; nothing is in flight afterwards.
`timescale 1ns / 1ps
`default_nettype none

module dual_channel_lux_calculation (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        stall_o,
  input  logic [dcl_pkg::CountW-1:0]  broadband_count_i,
  input  logic [dcl_pkg::CountW-1:0]  infrared_count_i,
  output logic                        valid_o,
  input  logic                        stall_i,
  output logic [dcl_pkg::LuxW-1:0]    lux_o
);
  import dcl_pkg::*;

  logic              div_valid;
  logic              div_stall;
  logic [CountW-1:0] div_bb;
  logic [CountW-1:0] div_ir;
  ratio_t            div_ratio;

  dcl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .stall_o (stall_o),
    .bb_i    (broadband_count_i),
    .ir_i    (infrared_count_i),
    .valid_o (div_valid),
    .stall_i (div_stall),
    .bb_o    (div_bb),
    .ir_o    (div_ir),
    .ratio_o (div_ratio)
  );

  logic              sel_valid_q, mul_valid_q, out_valid_q;
  logic              sel_en, mul_en, out_en;
  logic [CountW-1:0] sel_bb_q, sel_ir_q;
  coef_t             sel_coef_q, sel_coef_d;
  logic [ProdW-1:0]  pos_q, pos_d, neg_q, neg_d;
  logic [LuxW-1:0]   lux_q, lux_d;
  logic [ProdW-1:0]  diff;
  logic [ProdW:0]    acc;
  logic [ProdW-LuxShift:0] scaled;

  assign out_en    = !out_valid_q || !stall_i;
  assign mul_en    = !mul_valid_q || out_en;
  assign sel_en    = !sel_valid_q || mul_en;
  assign div_stall = !sel_en;

  assign sel_coef_d = seg_pick(div_ratio);

  assign pos_d = ProdW'(sel_bb_q) * ProdW'(sel_coef_q.b);
  assign neg_d = ProdW'(sel_ir_q) * ProdW'(sel_coef_q.m);

  // both counts carry the same x16 gain, folded into the shift
  assign diff   = pos_q - neg_q;
  assign acc    = {1'b0, diff} + LuxRound;
  assign scaled = acc[ProdW:LuxShift];

  always_comb begin
    if (neg_q >= pos_q) begin
      lux_d = '0;
    end else if (scaled[ProdW-LuxShift:LuxW] != '0) begin
      lux_d = '1;
    end else begin
      lux_d = scaled[LuxW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_valid_q <= 1'b0;
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (sel_en) begin
        sel_valid_q <= div_valid;
      end
      if (mul_en) begin
        mul_valid_q <= sel_valid_q;
      end
      if (out_en) begin
        out_valid_q <= mul_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel_en) begin
      sel_bb_q   <= div_bb;
      sel_ir_q   <= div_ir;
      sel_coef_q <= sel_coef_d;
    end
    if (mul_en) begin
      pos_q <= pos_d;
      neg_q <= neg_d;
    end
    if (out_en) begin
      lux_q <= lux_d;
    end
  end

  assign valid_o = out_valid_q;
  assign lux_o   = lux_q;

  // back pressure reaches the divider only when every later stage is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stall |-> (sel_valid_q && mul_valid_q && out_valid_q && stall_i))
    else $error("divider stalled while a later stage has room");

  // segments past the last breakpoint give both coefficients zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sel_valid_q && sel_coef_q.b == '0) |-> (sel_coef_q.m == '0))
    else $error("slope without intercept");

  // a non-positive difference must produce zero lux
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mul_valid_q && out_en && neg_q >= pos_q) |=> (out_valid_q && lux_q == '0))
    else $error("negative difference not clamped");

endmodule

`default_nettype wire

>>> rtl/dcl_div.sv
`timescale 1ns / 1ps
`default_nettype none

module dcl_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        stall_o,
  input  logic [dcl_pkg::CountW-1:0]  bb_i,
  input  logic [dcl_pkg::CountW-1:0]  ir_i,
  output logic                        valid_o,
  input  logic                        stall_i,
  output logic [dcl_pkg::CountW-1:0]  bb_o,
  output logic [dcl_pkg::CountW-1:0]  ir_o,
  output dcl_pkg::ratio_t             ratio_o
);
  import dcl_pkg::*;

  localparam int unsigned NumStages = 4;

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] en;
  logic [NumStages-1:0] zero_q, zero_d;
  logic [NumStages-1:0] over_q, over_d;
  logic [CountW-1:0]    bb_q   [NumStages];
  logic [CountW-1:0]    ir_q   [NumStages];
  logic [CountW-1:0]    rem_q  [NumStages];
  logic [CountW-1:0]    rem_d  [NumStages];
  logic [QuotW-1:0]     quot_q [NumStages];
  logic [QuotW-1:0]     quot_d [NumStages];

  // a stage loads when it is empty or the next one loads (the last: when stall_i is low)
  always_comb begin
    en[NumStages-1] = !valid_q[NumStages-1] || !stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign stall_o = !en[0];

  always_comb begin : stage_comb
    // integer part: ir >= 2*bb means the ratio is past every breakpoint
    begin : pre_stage
      logic q0;
      q0        = ir_i >= bb_i;
      zero_d[0] = bb_i == '0;
      over_d[0] = {1'b0, ir_i} >= {bb_i, 1'b0};
      rem_d[0]  = q0 ? ir_i - bb_i : ir_i;
      quot_d[0] = {q0, {(QuotW-1){1'b0}}};
    end

    // fraction bits: steps 1-4, 5-7, 8-10
    begin : step_stage1
      logic [CountW:0]   s;
      logic [CountW-1:0] r;
      logic [QuotW-1:0]  q;
      r = rem_q[0];
      q = quot_q[0];
      for (int j = 1; j <= 4; j++) begin
        s = div_step(r, bb_q[0]);
        q[QuotW-1-j] = s[CountW];
        r = s[CountW-1:0];
      end
      rem_d[1]  = r;
      quot_d[1] = q;
      zero_d[1] = zero_q[0];
      over_d[1] = over_q[0];
    end

    begin : step_stage2
      logic [CountW:0]   s;
      logic [CountW-1:0] r;
      logic [QuotW-1:0]  q;
      r = rem_q[1];
      q = quot_q[1];
      for (int j = 5; j <= 7; j++) begin
        s = div_step(r, bb_q[1]);
        q[QuotW-1-j] = s[CountW];
        r = s[CountW-1:0];
      end
      rem_d[2]  = r;
      quot_d[2] = q;
      zero_d[2] = zero_q[1];
      over_d[2] = over_q[1];
    end

    begin : step_stage3
      logic [CountW:0]   s;
      logic [CountW-1:0] r;
      logic [QuotW-1:0]  q;
      r = rem_q[2];
      q = quot_q[2];
      for (int j = 8; j <= 10; j++) begin
        s = div_step(r, bb_q[2]);
        q[QuotW-1-j] = s[CountW];
        r = s[CountW-1:0];
      end
      rem_d[3]  = r;
      quot_d[3] = q;
      zero_d[3] = zero_q[2];
      over_d[3] = over_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      bb_q[0]   <= bb_i;
      ir_q[0]   <= ir_i;
      rem_q[0]  <= rem_d[0];
      quot_q[0] <= quot_d[0];
      zero_q[0] <= zero_d[0];
      over_q[0] <= over_d[0];
    end
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) begin
        bb_q[k]   <= bb_q[k-1];
        ir_q[k]   <= ir_q[k-1];
        rem_q[k]  <= rem_d[k];
        quot_q[k] <= quot_d[k];
        zero_q[k] <= zero_d[k];
        over_q[k] <= over_d[k];
      end
    end
  end

  assign valid_o       = valid_q[NumStages-1];
  assign bb_o          = bb_q[NumStages-1];
  assign ir_o          = ir_q[NumStages-1];
  assign ratio_o.zero  = zero_q[NumStages-1];
  assign ratio_o.over  = over_q[NumStages-1];
  assign ratio_o.quot  = quot_q[NumStages-1];

endmodule

`default_nettype wire
